### hw/rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold in the same cycle
`define SCPT_ASSERT_NOW(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// condition that must hold in the next cycle
`define SCPT_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

### hw/rtl/scpt_pkg.sv
// widths, register indexes, colors and the result record of the position tracker
// no dependencies
package scpt_pkg;

   localparam int DP_BITS        = 64;
   localparam int SPR_BITS       = 16;
   localparam int PERIOD_BITS    = 48;
   localparam int DELAY_BITS     = 16;
   localparam int COLOR_BITS     = 24;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 48;
   localparam int CNT_BITS       = 7;

   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;

   localparam csr_index_type CSR_STEPS  = 2'd0;
   localparam csr_index_type CSR_PERIOD = 2'd1;
   localparam csr_index_type CSR_SLEEP  = 2'd2;

   localparam logic [SPR_BITS-1:0]    RESET_STEPS  = 16'd200;
   localparam logic [PERIOD_BITS-1:0] RESET_PERIOD = 48'd60000;
   localparam logic [DELAY_BITS-1:0]  RESET_SLEEP  = 16'd50;

   localparam logic [COLOR_BITS-1:0] COLOR_OFF    = 24'h000000;
   localparam logic [COLOR_BITS-1:0] COLOR_WHITE  = 24'h222222;
   localparam logic [COLOR_BITS-1:0] COLOR_RED    = 24'h220000;
   localparam logic [COLOR_BITS-1:0] COLOR_GREEN  = 24'h002200;
   localparam logic [COLOR_BITS-1:0] COLOR_YELLOW = 24'h222200;

   typedef struct packed {
      logic                  step_pulse;
      logic                  step_clockwise;
      logic                  motor_reset;
      logic                  led_valid;
      logic [COLOR_BITS-1:0] led_color;
   } result_type;

endpackage

### hw/rtl/stepper_clock_position_tracker.sv
// stepper clock position tracker, top level with a shared add/subtract unit
// depends on scpt_pkg
//
//   channel | prefix | direction | carries
//   update  | req_   | in        | now_time and four button flags
//   result  | rsp_   | out       | step, direction, motor reset, led, sleep
//   config  | csr_   | in        | register index and write data
//
// a button update goes from ELAP straight to SLEEP, where its result is registered
// a normal update runs 16 multiply, 64 divide and 64 modulo iterations, and 17
// more for the position wrap when it steps, all through one 64-bit adder
// one update in flight; a finished result waits in the output register while the
// next update is accepted, and the block holds its last cycle until that register frees
// synchronous reset loads register defaults and clears position and times
module stepper_clock_position_tracker
   import scpt_pkg::*;
#(
   parameter int TIME_BITS = 48
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [TIME_BITS-1:0]      req_now_time,
   input  logic                      req_pause_req,
   input  logic                      req_reset_req,
   input  logic                      req_turn_cw_req,
   input  logic                      req_turn_ccw_req,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_step_pulse,
   output logic                      rsp_step_clockwise,
   output logic                      rsp_motor_reset,
   output logic                      rsp_led_valid,
   output logic [COLOR_BITS-1:0]     rsp_led_color,
   output logic                      rsp_motor_sleep,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  csr_index_type             csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   localparam int WRAP_SHIFT = DP_BITS - SPR_BITS - 1;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_ELAP  = 8'b0000_0010,
      ST_MUL   = 8'b0000_0100,
      ST_DIV   = 8'b0000_1000,
      ST_MOD   = 8'b0001_0000,
      ST_EVAL  = 8'b0010_0000,
      ST_WRAP  = 8'b0100_0000,
      ST_SLEEP = 8'b1000_0000
   } state_type;

   state_type                state_ff, state_in;
   logic [SPR_BITS-1:0]      spr_cfg_ff, spr_cfg_in;
   logic [PERIOD_BITS-1:0]   period_cfg_ff, period_cfg_in;
   logic [DELAY_BITS-1:0]    delay_cfg_ff, delay_cfg_in;
   logic [TIME_BITS-1:0]     origin_ff, origin_in;
   logic [TIME_BITS-1:0]     last_ff, last_in;
   logic [SPR_BITS-1:0]      pos_ff, pos_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   logic [TIME_BITS-1:0]     now_ff, now_in;
   logic                     pause_ff, pause_in;
   logic                     rst_ff, rst_in;
   logic                     cw_ff, cw_in;
   logic                     ccw_ff, ccw_in;
   logic [DP_BITS-1:0]       acc_ff, acc_in;
   logic [DP_BITS-1:0]       opnd_ff, opnd_in;
   logic [PERIOD_BITS-1:0]   rem_ff, rem_in;
   logic [PERIOD_BITS-1:0]   div_ff, div_in;
   logic [SPR_BITS-1:0]      mul_ff, mul_in;
   logic [CNT_BITS-1:0]      cnt_ff, cnt_in;
   result_type               res_ff, res_in;
   result_type               rsp_res_ff, rsp_res_in;
   logic                     rsp_sleep_ff, rsp_sleep_in;

   logic [SPR_BITS-1:0]      spr_eff;
   logic [PERIOD_BITS-1:0]   period_eff;
   logic [DP_BITS-1:0]       add_a, add_b;
   logic                     add_cin;
   logic [DP_BITS:0]         add_wide;
   logic [DP_BITS-1:0]       add_sum;
   logic                     add_carry;
   logic [PERIOD_BITS:0]     div_part;
   logic [PERIOD_BITS-1:0]   div_rem;
   logic [DP_BITS-1:0]       diff_sat;
   logic                     sleep_hit;
   logic                     cnt_last;

   assign spr_eff    = (spr_cfg_ff == '0) ? SPR_BITS'(1) : spr_cfg_ff;
   assign period_eff = (period_cfg_ff == '0) ? PERIOD_BITS'(1) : period_cfg_ff;
   assign div_part   = {rem_ff, acc_ff[DP_BITS-1]};
   assign cnt_last   = (cnt_ff == CNT_BITS'(1));

   // operand select for the shared adder
   always_comb begin
      add_a   = '0;
      add_b   = '0;
      add_cin = 1'b0;
      case (state_ff)
         ST_ELAP: begin
            add_a   = DP_BITS'(now_ff);
            add_b   = ~DP_BITS'(origin_ff);
            add_cin = 1'b1;
         end
         ST_MUL: begin
            add_a = {acc_ff[DP_BITS-2:0], 1'b0};
            add_b = mul_ff[SPR_BITS-1] ? opnd_ff : '0;
         end
         ST_DIV, ST_MOD, ST_WRAP: begin
            add_a   = DP_BITS'(div_part);
            add_b   = ~DP_BITS'(div_ff);
            add_cin = 1'b1;
         end
         ST_SLEEP: begin
            add_a   = DP_BITS'(now_ff);
            add_b   = ~DP_BITS'(last_ff);
            add_cin = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign add_wide  = {1'b0, add_a} + {1'b0, add_b} + (DP_BITS+1)'(add_cin);
   assign add_sum   = add_wide[DP_BITS-1:0];
   assign add_carry = add_wide[DP_BITS];

   // carry set means the trial subtraction did not borrow
   assign div_rem   = add_carry ? add_sum[PERIOD_BITS-1:0] : div_part[PERIOD_BITS-1:0];
   assign diff_sat  = add_carry ? add_sum : '0;
   assign sleep_hit = (diff_sat[DP_BITS-1:DELAY_BITS] != '0) ||
                      (diff_sat[DELAY_BITS-1:0] > delay_cfg_ff);

   always_comb begin
      state_in      = state_ff;
      spr_cfg_in    = spr_cfg_ff;
      period_cfg_in = period_cfg_ff;
      delay_cfg_in  = delay_cfg_ff;
      origin_in     = origin_ff;
      last_in       = last_ff;
      pos_in        = pos_ff;
      rsp_valid_in  = rsp_valid_ff;
      now_in        = now_ff;
      pause_in      = pause_ff;
      rst_in        = rst_ff;
      cw_in         = cw_ff;
      ccw_in        = ccw_ff;
      acc_in        = acc_ff;
      opnd_in       = opnd_ff;
      rem_in        = rem_ff;
      div_in        = div_ff;
      mul_in        = mul_ff;
      cnt_in        = cnt_ff;
      res_in        = res_ff;
      rsp_res_in    = rsp_res_ff;
      rsp_sleep_in  = rsp_sleep_ff;

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               now_in   = req_now_time;
               pause_in = req_pause_req;
               rst_in   = req_reset_req;
               cw_in    = req_turn_cw_req;
               ccw_in   = req_turn_ccw_req;
               state_in = ST_ELAP;
            end
         end
         ST_ELAP: begin
            res_in = '0;
            if (pause_ff || rst_ff || cw_ff || ccw_ff) begin
               origin_in = now_ff;
               pos_in    = '0;
               state_in  = ST_SLEEP;
               if (pause_ff) begin
                  res_in.led_color = COLOR_OFF;
               end else if (rst_ff) begin
                  res_in.led_valid   = 1'b1;
                  res_in.led_color   = COLOR_RED;
                  res_in.motor_reset = 1'b1;
               end else if (cw_ff) begin
                  res_in.led_valid      = 1'b1;
                  res_in.led_color      = COLOR_YELLOW;
                  res_in.step_pulse     = 1'b1;
                  res_in.step_clockwise = 1'b1;
                  last_in               = now_ff;
               end else begin
                  res_in.led_valid  = 1'b1;
                  res_in.led_color  = COLOR_GREEN;
                  res_in.step_pulse = 1'b1;
                  last_in           = now_ff;
               end
            end else begin
               res_in.led_valid = 1'b1;
               res_in.led_color = COLOR_WHITE;
               opnd_in          = diff_sat;
               acc_in           = '0;
               mul_in           = spr_eff;
               cnt_in           = CNT_BITS'(SPR_BITS);
               state_in         = ST_MUL;
            end
         end
         ST_MUL: begin
            // shift-add, multiplier bits msb first
            acc_in = add_sum;
            mul_in = {mul_ff[SPR_BITS-2:0], 1'b0};
            cnt_in = cnt_ff - CNT_BITS'(1);
            if (cnt_last) begin
               rem_in   = '0;
               div_in   = period_eff;
               cnt_in   = CNT_BITS'(DP_BITS);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            acc_in = {acc_ff[DP_BITS-2:0], add_carry};
            rem_in = div_rem;
            cnt_in = cnt_ff - CNT_BITS'(1);
            if (cnt_last) begin
               // quotient stays in acc as the next dividend
               rem_in   = '0;
               div_in   = PERIOD_BITS'(spr_eff);
               cnt_in   = CNT_BITS'(DP_BITS);
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            acc_in = {acc_ff[DP_BITS-2:0], add_carry};
            rem_in = div_rem;
            cnt_in = cnt_ff - CNT_BITS'(1);
            if (cnt_last) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (pos_ff != rem_ff[SPR_BITS-1:0]) begin
               res_in.step_pulse     = 1'b1;
               res_in.step_clockwise = 1'b1;
               last_in               = now_ff;
               // position + 1 left aligned, reduced by spr over 17 iterations
               acc_in   = (DP_BITS'(pos_ff) + DP_BITS'(1)) << WRAP_SHIFT;
               rem_in   = '0;
               div_in   = PERIOD_BITS'(spr_eff);
               cnt_in   = CNT_BITS'(SPR_BITS + 1);
               state_in = ST_WRAP;
            end else begin
               state_in = ST_SLEEP;
            end
         end
         ST_WRAP: begin
            acc_in = {acc_ff[DP_BITS-2:0], add_carry};
            rem_in = div_rem;
            cnt_in = cnt_ff - CNT_BITS'(1);
            if (cnt_last) begin
               pos_in   = div_rem[SPR_BITS-1:0];
               state_in = ST_SLEEP;
            end
         end
         ST_SLEEP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_res_in   = res_ff;
               rsp_sleep_in = sleep_hit;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_STEPS:  spr_cfg_in    = csr_data[SPR_BITS-1:0];
            CSR_PERIOD: period_cfg_in = csr_data[PERIOD_BITS-1:0];
            CSR_SLEEP:  delay_cfg_in  = csr_data[DELAY_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         spr_cfg_ff    <= RESET_STEPS;
         period_cfg_ff <= RESET_PERIOD;
         delay_cfg_ff  <= RESET_SLEEP;
         origin_ff     <= '0;
         last_ff       <= '0;
         pos_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         spr_cfg_ff    <= spr_cfg_in;
         period_cfg_ff <= period_cfg_in;
         delay_cfg_ff  <= delay_cfg_in;
         origin_ff     <= origin_in;
         last_ff       <= last_in;
         pos_ff        <= pos_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff       <= now_in;
      pause_ff     <= pause_in;
      rst_ff       <= rst_in;
      cw_ff        <= cw_in;
      ccw_ff       <= ccw_in;
      acc_ff       <= acc_in;
      opnd_ff      <= opnd_in;
      rem_ff       <= rem_in;
      div_ff       <= div_in;
      mul_ff       <= mul_in;
      cnt_ff       <= cnt_in;
      res_ff       <= res_in;
      rsp_res_ff   <= rsp_res_in;
      rsp_sleep_ff <= rsp_sleep_in;
   end

   assign req_ready          = (state_ff == ST_IDLE);
   assign csr_ready          = (state_ff == ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_step_pulse     = rsp_res_ff.step_pulse;
   assign rsp_step_clockwise = rsp_res_ff.step_clockwise;
   assign rsp_motor_reset    = rsp_res_ff.motor_reset;
   assign rsp_led_valid      = rsp_res_ff.led_valid;
   assign rsp_led_color      = rsp_res_ff.led_color;
   assign rsp_motor_sleep    = rsp_sleep_ff;

endmodule

### hw/rtl/scpt_checker.sv
// port-level checks for the position tracker, bound to the top level
// depends on scpt_pkg and assert_macros.svh
`include "assert_macros.svh"

module scpt_checker
   import scpt_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic                  rsp_step_pulse,
   input logic                  rsp_step_clockwise,
   input logic                  rsp_motor_reset,
   input logic                  rsp_led_valid,
   input logic [COLOR_BITS-1:0] rsp_led_color
);

   // a taken update keeps the block busy in the next cycle
   `SCPT_ASSERT_NEXT(busy_after_req, clock, reset, req_valid && req_ready, !req_ready, "ready right after update transfer")

   // pause result carries no color and no motor action
   `SCPT_ASSERT_NOW(pause_quiet, clock, reset, rsp_valid && !rsp_led_valid, (rsp_led_color == COLOR_OFF) && !rsp_step_pulse && !rsp_motor_reset, "pause result not quiet")

   // motor reset shows red and never steps
   `SCPT_ASSERT_NOW(reset_red, clock, reset, rsp_valid && rsp_motor_reset, (rsp_led_color == COLOR_RED) && !rsp_step_pulse, "motor reset result malformed")

   // direction only set together with a step
   `SCPT_ASSERT_NOW(dir_needs_step, clock, reset, rsp_valid && rsp_step_clockwise, rsp_step_pulse, "direction without step")

   `SCPT_ASSERT_NEXT(rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_led_color) && $stable(rsp_step_pulse), "stalled result changed")

endmodule

bind stepper_clock_position_tracker scpt_checker u_scpt_checker (.*);
